// ===== src/mrss_pkg.sv =====
// shared types and constants for the matrix row-sum sorter
// no dependencies; used by matrix_row_sum_sorter_top
package mrss_pkg;

   localparam int ELEM_W    = 16;  // matrix element width
   localparam int SUM_W     = 19;  // row sum width
   localparam int POS_W     = 3;   // row and column position width
   localparam int CNT_W     = 4;   // row_count and col_count register width
   localparam int CSR_IDX_W = 2;   // register index width
   localparam int CSR_DAT_W = 4;   // register write data width

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,        // taking elements, summing rows
      ST_SORT_LOAD,   // fetch pivot for outer index i
      ST_SORT_CMP,    // compare pivot against position j, exchange
      ST_SORT_STORE,  // write pivot back to position i
      ST_EMIT         // issue reads of the reordered matrix
   } state_type;

endpackage

// ===== src/matrix_row_sum_sorter_top.sv =====
// matrix row-sum sorter: loads a matrix, sorts its rows by descending sum, emits it
// depends on mrss_pkg
//
// usage
//   req channel: one signed element word per accepted handshake, row-major order.
//   csr port: index 0 sets the rows in use, index 1 the columns in use (0 counts as
//   one, values above ROWS or COLS are clamped); writing either restarts the load.
//   rsp channel: after the last element the reordered matrix comes out row-major,
//   one word per element, each carrying its row sum, the best row and its sum.
// timing, with R rows and C columns in use
//   load: R*C elements, one per cycle while req_valid is high and req_stall low.
//   sort: one shared compare-exchange step per cycle, R*(R-1)/2 compares in
//   R-1 outer passes, each with a pivot fetch and a pivot store.
//   emit: the matrix store has one registered read port; one word per cycle when
//   the receiver does not stall; words pass a read stage and an output register.
//   req_stall stays high from the last element until every result word is taken.
// reset clears the sequencer, the load position and sets the registers to ROWS
// and COLS; when the receiver stalls, the output word holds and reads pause.
module matrix_row_sum_sorter_top #(
   parameter int ROWS = 8,
   parameter int COLS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // element input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mrss_pkg::ELEM_W-1:0]    req_element,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mrss_pkg::ELEM_W-1:0]    rsp_value,
   output logic [mrss_pkg::POS_W-1:0]            rsp_out_row,
   output logic [mrss_pkg::POS_W-1:0]            rsp_out_col,
   output logic signed [mrss_pkg::SUM_W-1:0]     rsp_row_total,
   output logic [mrss_pkg::CNT_W-1:0]            rsp_best_row,
   output logic signed [mrss_pkg::SUM_W-1:0]     rsp_best_sum,
   output logic                                  rsp_last,
   // configuration
   input  logic                                  csr_we,
   input  logic [mrss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mrss_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   localparam int DEPTH  = ROWS * COLS;
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int PW = mrss_pkg::POS_W;
   localparam int SW = mrss_pkg::SUM_W;
   localparam int EW = mrss_pkg::ELEM_W;
   localparam int CW = mrss_pkg::CNT_W;

   // sequencer and configuration
   mrss_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        row_count_ff, row_count_in;
   logic [CW-1:0]        col_count_ff, col_count_in;

   // load position and running sums
   logic [PW-1:0]        ld_row_ff, ld_row_in;
   logic [PW-1:0]        ld_col_ff, ld_col_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic [PW-1:0]        best_idx_ff, best_idx_in;
   logic signed [SW-1:0] best_sum_ff, best_sum_in;

   // row sums (sorted in place) and row order
   logic signed [SW-1:0] sums_ff [ROWS];
   logic signed [SW-1:0] sums_in [ROWS];
   logic [PW-1:0]        order_ff [ROWS];
   logic [PW-1:0]        order_in [ROWS];

   // exchange sort sequencer
   logic [PW-1:0]        i_ff, i_in;
   logic [PW-1:0]        j_ff, j_in;
   logic signed [SW-1:0] piv_sum_ff, piv_sum_in;
   logic [PW-1:0]        piv_row_ff, piv_row_in;

   // emit position
   logic [PW-1:0]        p_ff, p_in;
   logic [PW-1:0]        c_ff, c_in;

   // read stage
   logic                 rd_valid_ff, rd_valid_in;
   logic [PW-1:0]        rd_row_ff, rd_row_in;
   logic [PW-1:0]        rd_col_ff, rd_col_in;
   logic signed [SW-1:0] rd_total_ff, rd_total_in;
   logic                 rd_last_ff, rd_last_in;
   logic signed [EW-1:0] rd_data_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [EW-1:0] value_ff, value_in;
   logic [PW-1:0]        out_row_ff, out_row_in;
   logic [PW-1:0]        out_col_ff, out_col_in;
   logic signed [SW-1:0] total_ff, total_in;
   logic                 last_ff, last_in;

   // matrix store
   logic signed [EW-1:0] mem [DEPTH];

   // combinational helpers
   logic [CW-1:0]        rows_used, cols_used;
   logic [PW-1:0]        rows_m1, cols_m1;
   logic                 req_take;
   logic                 out_load;
   logic                 rd_issue;
   logic signed [SW-1:0] sum_new;
   logic [PW-1:0]        sum_rd_idx;
   logic signed [SW-1:0] sum_rd;
   logic [PW-1:0]        order_rd;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;

   // clamp the register values to the usable range
   always_comb begin
      priority if (row_count_ff == '0) begin
         rows_used = CW'(1);
      end else if (row_count_ff > CW'(ROWS)) begin
         rows_used = CW'(ROWS);
      end else begin
         rows_used = row_count_ff;
      end
      priority if (col_count_ff == '0) begin
         cols_used = CW'(1);
      end else if (col_count_ff > CW'(COLS)) begin
         cols_used = CW'(COLS);
      end else begin
         cols_used = col_count_ff;
      end
   end
   assign rows_m1 = PW'(rows_used - CW'(1));
   assign cols_m1 = PW'(cols_used - CW'(1));

   // handshakes: elements only in the load state with the output side empty
   assign req_stall = !(state_ff == mrss_pkg::ST_LOAD && !rd_valid_ff && !rsp_valid_ff);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign rd_issue  = (state_ff == mrss_pkg::ST_EMIT) && (!rd_valid_ff || out_load);

   // shared read port of the sums and order arrays
   always_comb begin
      unique case (state_ff)
         mrss_pkg::ST_SORT_LOAD: sum_rd_idx = i_ff;
         mrss_pkg::ST_SORT_CMP:  sum_rd_idx = j_ff;
         default:                sum_rd_idx = p_ff;
      endcase
   end
   assign sum_rd   = sums_ff[sum_rd_idx[RW-1:0]];
   assign order_rd = order_ff[sum_rd_idx[RW-1:0]];

   // running row sum of the incoming word
   assign sum_new = ((ld_col_ff == '0) ? SW'(0) : acc_ff) + SW'(req_element);

   // store addresses
   assign wr_addr = ADDR_W'(int'(ld_row_ff) * COLS + int'(ld_col_ff));
   assign rd_addr = ADDR_W'(int'(order_rd) * COLS + int'(c_ff));

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      ld_row_in    = ld_row_ff;
      ld_col_in    = ld_col_ff;
      acc_in       = acc_ff;
      best_idx_in  = best_idx_ff;
      best_sum_in  = best_sum_ff;
      sums_in      = sums_ff;
      order_in     = order_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      piv_sum_in   = piv_sum_ff;
      piv_row_in   = piv_row_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      rd_valid_in  = rd_valid_ff;
      rd_row_in    = rd_row_ff;
      rd_col_in    = rd_col_ff;
      rd_total_in  = rd_total_ff;
      rd_last_in   = rd_last_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      total_in     = total_ff;
      last_in      = last_ff;

      unique case (state_ff)
         mrss_pkg::ST_LOAD: begin
            if (req_take) begin
               acc_in = sum_new;
               if (ld_col_ff != cols_m1) begin
                  ld_col_in = ld_col_ff + PW'(1);
               end else begin
                  // row complete: keep its sum, track the first largest
                  ld_col_in = '0;
                  sums_in[ld_row_ff[RW-1:0]] = sum_new;
                  if (ld_row_ff == '0 || sum_new > best_sum_ff) begin
                     best_sum_in = sum_new;
                     best_idx_in = ld_row_ff;
                  end
                  if (ld_row_ff != rows_m1) begin
                     ld_row_in = ld_row_ff + PW'(1);
                  end else begin
                     // matrix complete: start the sort from identity order
                     ld_row_in = '0;
                     for (int k = 0; k < ROWS; k++) begin
                        order_in[k] = PW'(k);
                     end
                     i_in = '0;
                     p_in = '0;
                     c_in = '0;
                     if (rows_m1 == '0) begin
                        state_in = mrss_pkg::ST_EMIT;
                     end else begin
                        state_in = mrss_pkg::ST_SORT_LOAD;
                     end
                  end
               end
            end
         end

         mrss_pkg::ST_SORT_LOAD: begin
            piv_sum_in = sum_rd;
            piv_row_in = order_rd;
            j_in       = i_ff + PW'(1);
            state_in   = mrss_pkg::ST_SORT_CMP;
         end

         mrss_pkg::ST_SORT_CMP: begin
            // exchange pivot with position j when the pivot is smaller
            if (piv_sum_ff < sum_rd) begin
               sums_in[j_ff[RW-1:0]]  = piv_sum_ff;
               order_in[j_ff[RW-1:0]] = piv_row_ff;
               piv_sum_in = sum_rd;
               piv_row_in = order_rd;
            end
            if (j_ff != rows_m1) begin
               j_in = j_ff + PW'(1);
            end else begin
               state_in = mrss_pkg::ST_SORT_STORE;
            end
         end

         mrss_pkg::ST_SORT_STORE: begin
            sums_in[i_ff[RW-1:0]]  = piv_sum_ff;
            order_in[i_ff[RW-1:0]] = piv_row_ff;
            if (i_ff + PW'(1) != rows_m1) begin
               i_in     = i_ff + PW'(1);
               state_in = mrss_pkg::ST_SORT_LOAD;
            end else begin
               state_in = mrss_pkg::ST_EMIT;
            end
         end

         mrss_pkg::ST_EMIT: begin
            if (rd_issue) begin
               rd_row_in   = p_ff;
               rd_col_in   = c_ff;
               rd_total_in = sum_rd;
               rd_last_in  = (p_ff == rows_m1) && (c_ff == cols_m1);
               if (c_ff != cols_m1) begin
                  c_in = c_ff + PW'(1);
               end else begin
                  c_in = '0;
                  if (p_ff != rows_m1) begin
                     p_in = p_ff + PW'(1);
                  end else begin
                     state_in = mrss_pkg::ST_LOAD;
                  end
               end
            end
         end

         default: begin
            state_in = mrss_pkg::ST_LOAD;
         end
      endcase

      // read stage occupancy
      if (rd_issue) begin
         rd_valid_in = 1'b1;
      end else if (out_load) begin
         rd_valid_in = 1'b0;
      end

      // output register
      if (out_load) begin
         rsp_valid_in = 1'b1;
         value_in     = rd_data_ff;
         out_row_in   = rd_row_ff;
         out_col_in   = rd_col_ff;
         total_in     = rd_total_ff;
         last_in      = rd_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes restart the load
      if (csr_we) begin
         unique case (csr_index)
            mrss_pkg::CSR_ROW_COUNT: begin
               row_count_in = CW'(csr_wdata);
               ld_row_in    = '0;
               ld_col_in    = '0;
            end
            mrss_pkg::CSR_COL_COUNT: begin
               col_count_in = CW'(csr_wdata);
               ld_row_in    = '0;
               ld_col_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrss_pkg::ST_LOAD;
         row_count_ff <= CW'(ROWS);
         col_count_ff <= CW'(COLS);
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         best_idx_ff  <= '0;
         best_sum_ff  <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         p_ff         <= '0;
         c_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < ROWS; k++) begin
            order_ff[k] <= PW'(k);
         end
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         best_idx_ff  <= best_idx_in;
         best_sum_ff  <= best_sum_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         p_ff         <= p_in;
         c_ff         <= c_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         order_ff     <= order_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sums_ff     <= sums_in;
      piv_sum_ff  <= piv_sum_in;
      piv_row_ff  <= piv_row_in;
      rd_row_ff   <= rd_row_in;
      rd_col_ff   <= rd_col_in;
      rd_total_ff <= rd_total_in;
      rd_last_ff  <= rd_last_in;
      value_ff    <= value_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      total_ff    <= total_in;
      last_ff     <= last_in;
   end

   // matrix store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_take) begin
         mem[wr_addr] <= req_element;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result word
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = value_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_row_total = total_ff;
   assign rsp_best_row  = CW'(best_idx_ff) + CW'(1);
   assign rsp_best_sum  = best_sum_ff;
   assign rsp_last      = last_ff;

endmodule
